// ----- sv/elfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// elfr_pkg
// Shared codes and types for the escaped length frame receiver.
// ----------------------------------------------------------------------------
package elfr_pkg;

    localparam logic [7:0] FRAME_CODE  = 8'h01;
    localparam logic [7:0] ESCAPE_CODE = 8'h1B;
    localparam logic [7:0] ESCAPE_XOR  = 8'h40;
    localparam logic [7:0] ZERO_CODE   = 8'hDB;
    localparam logic [7:0] BCAST_ADDR  = 8'hFF;
    localparam logic [7:0] NULL_ADDR   = 8'h00;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'hFF;
    localparam logic [7:0] MY_ADDRESS_RESET = 8'h00;

    localparam logic REG_MAX_LENGTH = 1'b0;
    localparam logic REG_MY_ADDRESS = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_address;
        logic       end_of_packet;
        logic [7:0] packet_length;
        logic       cut_short;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/escaped_length_frame_receiver.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_length_frame_receiver
// Byte-stuffed serial deframer: decodes escapes, checks length and address,
// emits address and payload bytes and marks the end of each packet.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while s_ready is high. Each item is decoded by
// one level of logic against the frame state registers and its result, if
// any, lands in a single output register; s_ready stays high while that
// register is empty or being drained, so throughput is one item per clock.
// Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once and
// must only be made while the block is idle.
module escaped_length_frame_receiver (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_wdata,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_data_byte,
    output logic            m_has_byte,
    output logic            m_is_address,
    output logic            m_end_of_packet,
    output logic [7:0]      m_packet_length,
    output logic            m_cut_short
);

    logic [7:0] max_length_reg;
    logic [7:0] my_address_reg;

    logic       in_frame_reg,     in_frame_next;
    logic       in_escape_reg,    in_escape_next;
    logic       have_length_reg,  have_length_next;
    logic       have_address_reg, have_address_next;
    logic [7:0] remaining_reg,    remaining_next;
    logic [7:0] stored_count_reg, stored_count_next;

    logic                 out_valid_reg;
    elfr_pkg::result_t    out_reg;
    elfr_pkg::result_t    res;
    logic                 res_valid;
    logic                 accept;
    logic [7:0]           dec;
    logic [7:0]           rem_dec;
    logic [7:0]           cnt_inc;
    logic                 addr_ok;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign rem_dec = (remaining_reg != 8'd0) ? remaining_reg - 8'd1 : 8'd0;
    assign cnt_inc = stored_count_reg + 8'd1;

    always_comb begin
        if (in_escape_reg) begin
            dec = s_rx_byte ^ elfr_pkg::ESCAPE_XOR;
        end else if (s_rx_byte == elfr_pkg::ZERO_CODE) begin
            dec = 8'd0;
        end else begin
            dec = s_rx_byte;
        end
    end

    assign addr_ok = (my_address_reg == 8'd0) || (dec == my_address_reg)
                  || (dec == elfr_pkg::NULL_ADDR) || (dec == elfr_pkg::BCAST_ADDR);

    always_comb begin
        in_frame_next     = in_frame_reg;
        in_escape_next    = in_escape_reg;
        have_length_next  = have_length_reg;
        have_address_next = have_address_reg;
        remaining_next    = remaining_reg;
        stored_count_next = stored_count_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (accept && s_rx_byte != 8'd0) begin
            if (s_rx_byte == elfr_pkg::FRAME_CODE) begin
                if (in_frame_reg) begin
                    res_valid         = 1'b1;
                    res.end_of_packet = 1'b1;
                    res.packet_length = stored_count_reg;
                    res.cut_short     = 1'b1;
                end
                in_escape_next    = 1'b0;
                have_length_next  = 1'b0;
                have_address_next = 1'b0;
                stored_count_next = 8'd0;
                in_frame_next     = (max_length_reg != 8'd0);
                remaining_next    = max_length_reg;
            end else if (in_frame_reg) begin
                if (s_rx_byte == elfr_pkg::ESCAPE_CODE) begin
                    in_escape_next = 1'b1;
                end else begin
                    in_escape_next = 1'b0;
                    if (have_address_reg) begin
                        res.data_byte = dec;
                        res.has_byte  = 1'b1;
                        if (remaining_reg == 8'd0) begin
                            res.has_byte      = 1'b0;
                            res.data_byte     = 8'd0;
                            in_frame_next     = 1'b0;
                            have_length_next  = 1'b0;
                            have_address_next = 1'b0;
                            stored_count_next = 8'd0;
                        end else if (rem_dec == 8'd0) begin
                            res_valid         = 1'b1;
                            res.end_of_packet = 1'b1;
                            res.packet_length = cnt_inc;
                            in_frame_next     = 1'b0;
                            have_length_next  = 1'b0;
                            have_address_next = 1'b0;
                            remaining_next    = 8'd0;
                            stored_count_next = 8'd0;
                        end else begin
                            res_valid         = 1'b1;
                            remaining_next    = rem_dec;
                            stored_count_next = cnt_inc;
                        end
                    end else if (have_length_reg) begin
                        if (addr_ok) begin
                            res_valid      = 1'b1;
                            res.data_byte  = dec;
                            res.has_byte   = 1'b1;
                            res.is_address = 1'b1;
                            if (rem_dec == 8'd0) begin
                                res.end_of_packet = 1'b1;
                                res.packet_length = 8'd1;
                                in_frame_next     = 1'b0;
                                have_length_next  = 1'b0;
                                remaining_next    = 8'd0;
                                stored_count_next = 8'd0;
                            end else begin
                                have_address_next = 1'b1;
                                remaining_next    = rem_dec;
                                stored_count_next = 8'd1;
                            end
                        end else begin
                            in_frame_next     = 1'b0;
                            have_length_next  = 1'b0;
                            remaining_next    = 8'd0;
                            stored_count_next = 8'd0;
                        end
                    end else if (dec != 8'd0 && dec < remaining_reg) begin
                        remaining_next   = dec;
                        have_length_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg   <= elfr_pkg::MAX_LENGTH_RESET;
            my_address_reg   <= elfr_pkg::MY_ADDRESS_RESET;
            in_frame_reg     <= 1'b0;
            in_escape_reg    <= 1'b0;
            have_length_reg  <= 1'b0;
            have_address_reg <= 1'b0;
            remaining_reg    <= 8'd0;
            stored_count_reg <= 8'd0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    elfr_pkg::REG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                    elfr_pkg::REG_MY_ADDRESS: my_address_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            in_frame_reg     <= in_frame_next;
            in_escape_reg    <= in_escape_next;
            have_length_reg  <= have_length_next;
            have_address_reg <= have_address_next;
            remaining_reg    <= remaining_next;
            stored_count_reg <= stored_count_next;
            if (res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_data_byte     = out_reg.data_byte;
    assign m_has_byte      = out_reg.has_byte;
    assign m_is_address    = out_reg.is_address;
    assign m_end_of_packet = out_reg.end_of_packet;
    assign m_packet_length = out_reg.packet_length;
    assign m_cut_short     = out_reg.cut_short;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Escaped length frame receiver: raw serial bytes in, decoded packet items out.
// A scoreboard decodes every accepted byte with its own copy of the frame
// state and registers, and checks each delivered item field by field. Both
// handshakes idle at random outside a steady phase; register settings change between drained phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 200000;

    class deframer_scoreboard;
        elfr_pkg::result_t expected_items[$];
        int         failures;
        logic [7:0] max_len;
        logic [7:0] own_addr;
        bit         framing;
        bit         escaping;
        bit         length_known;
        bit         address_known;
        logic [7:0] bytes_left;
        logic [7:0] bytes_stored;

        function new();
            failures = 0;
            max_len  = elfr_pkg::MAX_LENGTH_RESET;
            own_addr = elfr_pkg::MY_ADDRESS_RESET;
            clear_frame();
        endfunction

        function void set_reg(input logic idx, input logic [7:0] value);
            if (idx == elfr_pkg::REG_MAX_LENGTH) begin
                max_len = value;
            end else begin
                own_addr = value;
            end
        endfunction

        function void clear_frame();
            framing       = 1'b0;
            escaping      = 1'b0;
            length_known  = 1'b0;
            address_known = 1'b0;
            bytes_left    = '0;
            bytes_stored  = '0;
        endfunction

        function bit decode_byte(input logic [7:0] raw, output elfr_pkg::result_t r);
            logic [7:0] c;
            bit         hit;
            c   = raw;
            hit = 1'b0;
            r   = '0;
            if (c == 8'h00)
                return 1'b0;
            if (c == elfr_pkg::FRAME_CODE) begin
                if (framing) begin
                    r.end_of_packet = 1'b1;
                    r.packet_length = bytes_stored;
                    r.cut_short     = 1'b1;
                    hit = 1'b1;
                end
                clear_frame();
                if (max_len != 0) begin
                    framing    = 1'b1;
                    bytes_left = max_len;
                end
                return hit;
            end
            if (!framing)
                return 1'b0;
            if (c == elfr_pkg::ESCAPE_CODE) begin
                escaping = 1'b1;
                return 1'b0;
            end
            if (escaping) begin
                escaping = 1'b0;
                c = c ^ elfr_pkg::ESCAPE_XOR;
            end else if (c == elfr_pkg::ZERO_CODE) begin
                c = '0;
            end
            if (address_known) begin
                if (bytes_left == 0) begin
                    clear_frame();
                    return 1'b0;
                end
                bytes_stored = bytes_stored + 8'd1;
                bytes_left   = bytes_left - 8'd1;
                r.data_byte  = c;
                r.has_byte   = 1'b1;
                if (bytes_left == 0) begin
                    r.end_of_packet = 1'b1;
                    r.packet_length = bytes_stored;
                    clear_frame();
                end
                return 1'b1;
            end
            if (length_known) begin
                if (own_addr == 0 || c == own_addr || c == elfr_pkg::NULL_ADDR
                        || c == elfr_pkg::BCAST_ADDR) begin
                    bytes_stored  = 8'd1;
                    if (bytes_left != 0)
                        bytes_left = bytes_left - 8'd1;
                    address_known = 1'b1;
                    r.data_byte   = c;
                    r.has_byte    = 1'b1;
                    r.is_address  = 1'b1;
                    if (bytes_left == 0) begin
                        r.end_of_packet = 1'b1;
                        r.packet_length = 8'd1;
                        clear_frame();
                    end
                    return 1'b1;
                end
                clear_frame();
                return 1'b0;
            end
            if (c != 0 && c < bytes_left) begin
                bytes_left   = c;
                length_known = 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(input logic [7:0] raw);
            elfr_pkg::result_t r;
            if (decode_byte(raw, r))
                expected_items.push_back(r);
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        function void compare_field(input string field, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_item(input elfr_pkg::result_t got);
            elfr_pkg::result_t want;
            if (expected_items.size() == 0) begin
                $error("item delivered with none expected");
                failures++;
                return;
            end
            want = expected_items.pop_front();
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("has_byte", want.has_byte, got.has_byte);
            compare_field("is_address", want.is_address, got.is_address);
            compare_field("end_of_packet", want.end_of_packet, got.end_of_packet);
            compare_field("packet_length", want.packet_length, got.packet_length);
            compare_field("cut_short", want.cut_short, got.cut_short);
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_data_byte;
    logic       m_has_byte;
    logic       m_is_address;
    logic       m_end_of_packet;
    logic [7:0] m_packet_length;
    logic       m_cut_short;

    deframer_scoreboard sb;
    bit         steady;
    int         bytes_sent;
    int         cycles;
    logic [7:0] opening [0:23];

    escaped_length_frame_receiver DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_byte     (m_data_byte),
        .m_has_byte      (m_has_byte),
        .m_is_address    (m_is_address),
        .m_end_of_packet (m_end_of_packet),
        .m_packet_length (m_packet_length),
        .m_cut_short     (m_cut_short)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        elfr_pkg::result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.data_byte     = m_data_byte;
                got.has_byte      = m_has_byte;
                got.is_address    = m_is_address;
                got.end_of_packet = m_end_of_packet;
                got.packet_length = m_packet_length;
                got.cut_short     = m_cut_short;
                sb.check_item(got);
            end
            m_ready <= steady || ($urandom_range(99) >= 17);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_byte(b);
        if (b != 8'h00)
            bytes_sent++;
    endtask

    // encodes one decoded value, literal or escaped where both are possible, zero sometimes as the zero code
    task automatic send_value(input logic [7:0] v);
        logic [7:0] esc;
        bit         literal_ok;
        bit         escape_ok;
        esc        = v ^ elfr_pkg::ESCAPE_XOR;
        literal_ok = v != 8'h00 && v != elfr_pkg::FRAME_CODE
                  && v != elfr_pkg::ESCAPE_CODE && v != elfr_pkg::ZERO_CODE;
        escape_ok  = esc != 8'h00 && esc != elfr_pkg::FRAME_CODE
                  && esc != elfr_pkg::ESCAPE_CODE;
        if ($urandom_range(24) == 0)
            send_byte(8'h00);
        if (v == 8'h00 && $urandom_range(1) == 1) begin
            send_byte(elfr_pkg::ZERO_CODE);
        end else if (literal_ok && (!escape_ok || $urandom_range(3) != 0)) begin
            send_byte(v);
        end else begin
            send_byte(elfr_pkg::ESCAPE_CODE);
            send_byte(esc);
        end
    endtask

    task automatic send_frame();
        int         cap;
        int         len;
        int         n;
        int         roll;
        logic [7:0] addr;
        cap  = int'(sb.max_len);
        roll = $urandom_range(99);
        send_byte(elfr_pkg::FRAME_CODE);
        if (cap < 2 || roll < 8) begin
            send_value(($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(255, cap)));
            if (cap < 2 || $urandom_range(1) == 1)
                return;
            len = $urandom_range((cap - 1 > 10) ? 10 : cap - 1, 1);
        end else if (roll < 11) begin
            len = $urandom_range(cap - 1, 1);
        end else begin
            len = $urandom_range((cap - 1 > 10) ? 10 : cap - 1, 1);
        end
        send_value(8'(len));
        roll = $urandom_range(99);
        if (roll < 25)
            addr = 8'($urandom_range(255));
        else if (roll < 40)
            addr = elfr_pkg::NULL_ADDR;
        else if (roll < 55)
            addr = elfr_pkg::BCAST_ADDR;
        else if (sb.own_addr != 0)
            addr = sb.own_addr;
        else
            addr = 8'($urandom_range(255));
        send_value(addr);
        n = len - 1;
        if ($urandom_range(9) == 0)
            n = $urandom_range(n);
        for (int i = 0; i < n; i++)
            send_value(8'($urandom_range(255)));
    endtask

    task automatic run_phase(input int count);
        int target;
        int n;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 80) begin
                send_frame();
            end else begin
                n = $urandom_range(4, 1);
                repeat (n) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] max_value, input logic [7:0] addr_value);
        cfg_we    <= 1'b1;
        cfg_index <= elfr_pkg::REG_MAX_LENGTH;
        cfg_wdata <= max_value;
        @(posedge aclk);
        cfg_index <= elfr_pkg::REG_MY_ADDRESS;
        cfg_wdata <= addr_value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(elfr_pkg::REG_MAX_LENGTH, max_value);
        sb.set_reg(elfr_pkg::REG_MY_ADDRESS, addr_value);
    endtask

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = elfr_pkg::REG_MAX_LENGTH;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_rx_byte  = '0;
        m_ready    = 1'b0;
        steady     = 1'b0;
        bytes_sent = 0;
        cycles     = 0;
        sb         = new();
        // own address 33h, capacity 16: zero byte, bytes outside a frame,
        // bad lengths, cut with nothing stored, length one, foreign address,
        // broadcast and null addresses, escaped frame byte, escaped payload
        opening = '{8'h00, 8'h42, elfr_pkg::ESCAPE_CODE, elfr_pkg::FRAME_CODE,
                    elfr_pkg::ZERO_CODE, 8'h10, elfr_pkg::FRAME_CODE,
                    elfr_pkg::ESCAPE_CODE, 8'h41, 8'h33, elfr_pkg::FRAME_CODE, 8'h03,
                    8'h44, 8'h05, elfr_pkg::FRAME_CODE, 8'h04, elfr_pkg::BCAST_ADDR,
                    8'h00, elfr_pkg::ESCAPE_CODE, elfr_pkg::FRAME_CODE, 8'h02,
                    elfr_pkg::ZERO_CODE, elfr_pkg::ESCAPE_CODE, 8'h9B};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        run_phase(90);
        wait_drained();
        configure(8'd16, 8'h33);
        foreach (opening[i])
            send_byte(opening[i]);
        wait_drained();
        configure(8'd0, 8'h7E);
        run_phase(30);
        wait_drained();
        configure(8'd1, 8'h00);
        run_phase(25);
        wait_drained();
        configure(8'd255, 8'h01);
        steady = 1'b1;
        run_phase(100);
        wait_drained();
        steady = 1'b0;
        configure(8'd255, 8'hFF);
        run_phase(70);
        wait_drained();
        configure(8'd2, 8'h80);
        run_phase(50);
        wait_drained();
        repeat (3) begin
            configure(8'($urandom_range(255)), 8'($urandom_range(255)));
            run_phase(55);
            wait_drained();
        end
        configure(8'd255, 8'h00);
        run_phase(60);
        wait_drained();

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
